/* design/bmpfb_pkg.sv */
// ----------------------------------------------------------------------------
// bmpfb_pkg
// Shared constants and types of the BMP to framebuffer writer.
// ----------------------------------------------------------------------------
package bmpfb_pkg;

   localparam int DIM_WIDTH      = 13;
   localparam int COUNT_WIDTH    = 12;
   localparam int ADDR_WIDTH     = 24;
   localparam int VALUE_WIDTH    = 24;
   localparam int HPOS_WIDTH     = 6;
   localparam int CSR_IDX_WIDTH  = 2;

   localparam logic [DIM_WIDTH-1:0] MAX_DIMENSION = 13'd4096;
   localparam logic [HPOS_WIDTH-1:0] HEADER_BYTES = 6'd54;
   localparam logic [HPOS_WIDTH-1:0] HEADER_LAST  = 6'd53;
   localparam logic [HPOS_WIDTH-1:0] WIDTH_OFS    = 6'd18;
   localparam logic [HPOS_WIDTH-1:0] HEIGHT_OFS   = 6'd22;
   localparam logic [HPOS_WIDTH-1:0] BITS_OFS     = 6'd28;

   localparam logic [DIM_WIDTH-1:0] RESET_WIDTH  = 13'd800;
   localparam logic [DIM_WIDTH-1:0] RESET_HEIGHT = 13'd480;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OUTPUT_FORMAT = 2'd2;

   // Output formats.
   localparam logic FMT_XRGB8888 = 1'b0;
   localparam logic FMT_RGB565   = 1'b1;

   // Byte phases within a pixel triple.
   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] col;
      logic [COUNT_WIDTH-1:0] row;
   } pos_type;

endpackage

/* design/bmpfb_req_if.sv */
// ----------------------------------------------------------------------------
// bmpfb_req_if
// Input byte channel: one BMP file byte per transaction.
// ----------------------------------------------------------------------------
interface bmpfb_req_if import bmpfb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       first_byte;

   modport source (output valid, output file_byte, output first_byte, input ready);
   modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

/* design/bmpfb_rsp_if.sv */
// ----------------------------------------------------------------------------
// bmpfb_rsp_if
// Result channel: one framebuffer write per transaction.
// ----------------------------------------------------------------------------
interface bmpfb_rsp_if import bmpfb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ADDR_WIDTH-1:0]  pixel_address;
   logic [VALUE_WIDTH-1:0] pixel_value;
   logic                   last_pixel;
   logic                   size_mismatch;

   modport source (output valid, output pixel_address, output pixel_value,
                   output last_pixel, output size_mismatch, input ready);
   modport sink   (input valid, input pixel_address, input pixel_value,
                   input last_pixel, input size_mismatch, output ready);
endinterface

/* design/bmpfb_pixel_calc.sv */
// ----------------------------------------------------------------------------
// bmpfb_pixel_calc
// Converts one BGR triple and computes its flipped framebuffer address,
// the end-of-frame flag and the next column and row.
// ----------------------------------------------------------------------------
module bmpfb_pixel_calc import bmpfb_pkg::*; (
   input  pos_type                pos,
   input  logic [DIM_WIDTH-1:0]   eff_width,
   input  logic [DIM_WIDTH-1:0]   eff_height,
   input  logic                   out_format,
   input  logic [7:0]             blue,
   input  logic [7:0]             green,
   input  logic [7:0]             red,
   output logic [ADDR_WIDTH-1:0]  pixel_address,
   output logic [VALUE_WIDTH-1:0] pixel_value,
   output logic                   last_pixel,
   output pos_type                next_pos
);

   logic [DIM_WIDTH-1:0]   width_m1;
   logic [DIM_WIDTH-1:0]   height_m1;
   logic                   col_over;
   logic                   row_over;
   logic [COUNT_WIDTH-1:0] col_c;
   logic [COUNT_WIDTH-1:0] row_c;
   logic                   col_end;
   logic                   row_end;
   logic [COUNT_WIDTH-1:0] flip_row;
   logic [COUNT_WIDTH+DIM_WIDTH-1:0] row_base;
   logic [COUNT_WIDTH+DIM_WIDTH-1:0] addr_sum;

   assign width_m1  = eff_width - 13'd1;
   assign height_m1 = eff_height - 13'd1;

   // Positions past a shrunken screen clamp to the last column or row.
   assign col_over = {1'b0, pos.col} >= eff_width;
   assign row_over = {1'b0, pos.row} >= eff_height;
   assign col_c    = col_over ? width_m1[COUNT_WIDTH-1:0] : pos.col;
   assign row_c    = row_over ? height_m1[COUNT_WIDTH-1:0] : pos.row;
   assign col_end  = {1'b0, col_c} == width_m1;
   assign row_end  = {1'b0, row_c} == height_m1;

   assign last_pixel = col_over || row_over || (col_end && row_end);

   assign flip_row = height_m1[COUNT_WIDTH-1:0] - row_c;
   assign row_base = {{DIM_WIDTH{1'b0}}, flip_row} * {{COUNT_WIDTH{1'b0}}, eff_width};
   assign addr_sum = row_base + {{DIM_WIDTH{1'b0}}, col_c};
   assign pixel_address = addr_sum[ADDR_WIDTH-1:0];

   always_comb begin
      if (out_format == FMT_RGB565) begin
         pixel_value = {8'd0, red[7:3], green[7:2], blue[7:3]};
      end else begin
         pixel_value = {red, green, blue};
      end
   end

   always_comb begin
      if (col_end) begin
         next_pos.col = '0;
         next_pos.row = row_c + 12'd1;
      end else begin
         next_pos.col = col_c + 12'd1;
         next_pos.row = row_c;
      end
   end

endmodule

/* design/bmp_to_framebuffer_writer_core.sv */
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_writer_core
// Parses a BMP byte stream, checks its header against the screen settings
// and emits one converted, vertically flipped framebuffer write per pixel.
// ----------------------------------------------------------------------------
// A pixel write is registered and appears in the cycle after its red byte is accepted.
// Throughput: one byte per cycle; parsing and conversion run in one pass
// between the accepted byte and the result register.
// A stalled result register holds the input off until it is taken.
// Reset (synchronous) clears all parsing state and loads 800x480 XRGB8888.
// ----------------------------------------------------------------------------
module bmp_to_framebuffer_writer_core import bmpfb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   bmpfb_req_if.sink                req_if,
   bmpfb_rsp_if.source              rsp_if,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [DIM_WIDTH-1:0]     csr_wr_data
);

   logic [DIM_WIDTH-1:0]  screen_width_ff;
   logic [DIM_WIDTH-1:0]  screen_height_ff;
   logic                  output_format_ff;

   logic [HPOS_WIDTH-1:0] hpos_ff,      hpos_in;
   logic [31:0]           width_word_ff,  width_word_in;
   logic [31:0]           height_word_ff, height_word_in;
   logic [31:0]           bits_word_ff,   bits_word_in;
   logic [1:0]            phase_ff,     phase_in;
   logic [15:0]           hold_ff,      hold_in;
   pos_type               pos_ff,       pos_in;
   logic                  done_ff,      done_in;
   logic                  mismatch_ff,  mismatch_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_WIDTH-1:0]  rsp_addr_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_last_ff;
   logic                   rsp_mismatch_ff;

   // State as seen by the current byte: a first byte starts from scratch.
   logic [HPOS_WIDTH-1:0] cur_hpos;
   logic [31:0]           cur_width_word;
   logic [31:0]           cur_height_word;
   logic [31:0]           cur_bits_word;
   logic [1:0]            cur_phase;
   logic [15:0]           cur_hold;
   pos_type               cur_pos;
   logic                  cur_done;
   logic                  cur_mismatch;

   logic [DIM_WIDTH-1:0]   eff_width;
   logic [DIM_WIDTH-1:0]   eff_height;
   logic [28:0]            bytes_pp;
   logic [HPOS_WIDTH-1:0]  word_ofs;
   logic                   req_fire;
   logic                   emit;

   logic [ADDR_WIDTH-1:0]  calc_addr;
   logic [VALUE_WIDTH-1:0] calc_value;
   logic                   calc_last;
   pos_type                calc_next;

   always_comb begin
      if (screen_width_ff == '0) begin
         eff_width = 13'd1;
      end else if (screen_width_ff > MAX_DIMENSION) begin
         eff_width = MAX_DIMENSION;
      end else begin
         eff_width = screen_width_ff;
      end
      if (screen_height_ff == '0) begin
         eff_height = 13'd1;
      end else if (screen_height_ff > MAX_DIMENSION) begin
         eff_height = MAX_DIMENSION;
      end else begin
         eff_height = screen_height_ff;
      end
   end

   assign bytes_pp = (output_format_ff == FMT_RGB565) ? 29'd2 : 29'd4;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      if (req_if.first_byte) begin
         cur_hpos        = '0;
         cur_width_word  = '0;
         cur_height_word = '0;
         cur_bits_word   = '0;
         cur_phase       = PHASE_BLUE;
         cur_hold        = '0;
         cur_pos         = '0;
         cur_done        = 1'b0;
         cur_mismatch    = 1'b0;
      end else begin
         cur_hpos        = hpos_ff;
         cur_width_word  = width_word_ff;
         cur_height_word = height_word_ff;
         cur_bits_word   = bits_word_ff;
         cur_phase       = phase_ff;
         cur_hold        = hold_ff;
         cur_pos         = pos_ff;
         cur_done        = done_ff;
         cur_mismatch    = mismatch_ff;
      end
   end

   bmpfb_pixel_calc u_calc (
      .pos           (cur_pos),
      .eff_width     (eff_width),
      .eff_height    (eff_height),
      .out_format    (output_format_ff),
      .blue          (cur_hold[7:0]),
      .green         (cur_hold[15:8]),
      .red           (req_if.file_byte),
      .pixel_address (calc_addr),
      .pixel_value   (calc_value),
      .last_pixel    (calc_last),
      .next_pos      (calc_next)
   );

   always_comb begin
      hpos_in        = cur_hpos;
      width_word_in  = cur_width_word;
      height_word_in = cur_height_word;
      bits_word_in   = cur_bits_word;
      phase_in       = cur_phase;
      hold_in        = cur_hold;
      pos_in         = cur_pos;
      done_in        = cur_done;
      mismatch_in    = cur_mismatch;
      emit           = 1'b0;
      word_ofs       = '0;

      if (cur_hpos < HEADER_BYTES) begin
         hpos_in = cur_hpos + 6'd1;
         if (cur_hpos inside {[18:21]}) begin
            word_ofs = cur_hpos - WIDTH_OFS;
            width_word_in[{word_ofs[1:0], 3'b000} +: 8] = req_if.file_byte;
         end else if (cur_hpos inside {[22:25]}) begin
            word_ofs = cur_hpos - HEIGHT_OFS;
            height_word_in[{word_ofs[1:0], 3'b000} +: 8] = req_if.file_byte;
         end else if (cur_hpos inside {[28:31]}) begin
            word_ofs = cur_hpos - BITS_OFS;
            bits_word_in[{word_ofs[1:0], 3'b000} +: 8] = req_if.file_byte;
         end
         // The final header byte carries no word, so the words are complete.
         if (cur_hpos == HEADER_LAST) begin
            mismatch_in = (cur_width_word != {19'd0, eff_width}) ||
                          (cur_height_word != {19'd0, eff_height}) ||
                          cur_bits_word[31] || (cur_bits_word[31:3] != bytes_pp);
         end
      end else if (!cur_done) begin
         case (cur_phase)
            PHASE_BLUE: begin
               hold_in  = {8'd0, req_if.file_byte};
               phase_in = PHASE_GREEN;
            end
            PHASE_GREEN: begin
               hold_in  = {req_if.file_byte, cur_hold[7:0]};
               phase_in = PHASE_RED;
            end
            default: begin
               phase_in = PHASE_BLUE;
               emit     = 1'b1;
               if (calc_last) begin
                  done_in = 1'b1;
               end else begin
                  pos_in = calc_next;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= RESET_WIDTH;
         screen_height_ff <= RESET_HEIGHT;
         output_format_ff <= FMT_XRGB8888;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wr_data;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wr_data;
            CSR_OUTPUT_FORMAT: output_format_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpos_ff        <= '0;
         width_word_ff  <= '0;
         height_word_ff <= '0;
         bits_word_ff   <= '0;
         phase_ff       <= PHASE_BLUE;
         hold_ff        <= '0;
         pos_ff         <= '0;
         done_ff        <= 1'b0;
         mismatch_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            hpos_ff        <= hpos_in;
            width_word_ff  <= width_word_in;
            height_word_ff <= height_word_in;
            bits_word_ff   <= bits_word_in;
            phase_ff       <= phase_in;
            hold_ff        <= hold_in;
            pos_ff         <= pos_in;
            done_ff        <= done_in;
            mismatch_ff    <= mismatch_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_addr_ff     <= calc_addr;
         rsp_value_ff    <= calc_value;
         rsp_last_ff     <= calc_last;
         rsp_mismatch_ff <= cur_mismatch;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.pixel_address = rsp_addr_ff;
   assign rsp_if.pixel_value   = rsp_value_ff;
   assign rsp_if.last_pixel    = rsp_last_ff;
   assign rsp_if.size_mismatch = rsp_mismatch_ff;

endmodule

/* design/bmpfb_checker.sv */
// ----------------------------------------------------------------------------
// bmpfb_checker
// Port-level assertions for the BMP to framebuffer writer, bound to the top.
// ----------------------------------------------------------------------------
module bmpfb_checker import bmpfb_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ADDR_WIDTH-1:0]  rsp_addr,
   input logic [VALUE_WIDTH-1:0] rsp_value,
   input logic                   rsp_last
);

   // A pending result is not withdrawn before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_addr) && $stable(rsp_value) &&
                                  $stable(rsp_last))
      else $error("result payload changed while stalled");

   // The input is held off only by a full, stalled result register.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a stalled result");

   // A fresh result always comes from a byte accepted in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !($past(rsp_valid) && !$past(rsp_ready)) |->
         $past(req_valid) && $past(req_ready))
      else $error("result appeared without an accepted byte");

endmodule

bind bmp_to_framebuffer_writer_core bmpfb_checker u_bmpfb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_addr  (rsp_if.pixel_address),
   .rsp_value (rsp_if.pixel_value),
   .rsp_last  (rsp_if.last_pixel)
);
